// ===== src/rita_pkg.sv =====
// ============================================================================
// rita_pkg
// Shared constants, types and helpers for the radix integer-to-ASCII block.
// ============================================================================
package rita_pkg;

    // Number width and port widths.
    localparam int VALUE_BITS = 32;
    localparam int IN_W       = 32;
    localparam int RADIX_W    = 8;
    localparam int CHAR_W     = 8;

    // Radix range and the narrow width that holds any legal radix.
    localparam int RADIX_MIN  = 2;
    localparam int RADIX_MAX  = 16;
    localparam int RAD_W      = 5;
    localparam int DIGIT_W    = 4;

    // Divider: quotient bits settled per cycle, and cycles per digit.
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
    localparam int STEP_W        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Digit stack: at most VALUE_BITS digits (base 2).
    localparam int STACK_DEPTH = VALUE_BITS;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // ASCII codes.
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OUT_ERR,
        OUT_ZERO,
        OUT_MINUS,
        OUT_DIGIT
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_in;
        logic     div_step;
        logic     rd_en;
        logic     out_load;
        out_sel_t out_sel;
        logic     out_final;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic bad;
        logic is_zero;
        logic neg;
        logic div_last;
        logic quo_zero;
        logic cnt_zero;
        logic out_free;
    } dp_status_t;

    // Lower-case ASCII for one digit value.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            digit_char = CH_ZERO + ext;
        end
        else begin
            digit_char = CH_LOWER_A + ext - 8'd10;
        end
    endfunction

endpackage

// ===== src/radix_integer_to_ascii.sv =====
// ============================================================================
// radix_integer_to_ascii
// Converts a 32-bit value to lower-case ASCII text in base 2 to 16.
// ============================================================================
// Usage:
// One request on the input channel (value, signed_mode, radix) produces a
// burst of character requests on the output channel, most significant digit
// first, with final_res set on the last one. A negative signed value gets a
// leading '-', zero gives a single '0', and a radix outside 2 to 16 gives one
// request with bad_radix set and character 0.
// The block converts one value at a time; in_ready is high only while idle.
// Digits come from a shared divider that settles 8 quotient bits a cycle;
// they are pushed onto a digit stack and read back in reverse, each
// character through a stack read and then the output register.
// The output is registered; when the receiver holds out_ready low, the
// conversion simply waits with the pending character held. Reset clears the
// controller and the output valid flag; no request is in flight afterwards.
// ============================================================================
module radix_integer_to_ascii (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rita_pkg::IN_W-1:0]       value,
    input  logic                            signed_mode,
    input  logic [rita_pkg::RADIX_W-1:0]    radix,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rita_pkg::CHAR_W-1:0]     character,
    output logic                            final_res,
    output logic                            bad_radix
);

    rita_pkg::ctrl_cmd_t  cmd;
    rita_pkg::dp_status_t status;

    // Controller: sequences load, divide, sign, readout.
    rita_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: divider, digit stack and output register.
    rita_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .signed_mode (signed_mode),
        .radix       (radix),
        .character   (character),
        .final_res   (final_res),
        .bad_radix   (bad_radix),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

// ===== src/rita_ctrl.sv =====
// ============================================================================
// rita_ctrl
// Controller state machine: sequences load, division, stack readout and the
// hand-off of each character to the output register.
// ============================================================================
module rita_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rita_pkg::dp_status_t  status,
    output rita_pkg::ctrl_cmd_t   cmd
);

    rita_pkg::state_t state_reg;
    rita_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= rita_pkg::ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.out_sel   = rita_pkg::OUT_DIGIT;
        cmd.out_final = 1'b0;

        case (state_reg)
            rita_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid) begin
                    state_next = rita_pkg::ST_CHECK;
                end
            end
            rita_pkg::ST_CHECK:
            begin
                if (status.bad || status.is_zero) begin
                    if (status.out_free) begin
                        cmd.out_load  = 1'b1;
                        cmd.out_final = 1'b1;
                        cmd.out_sel   = status.bad ? rita_pkg::OUT_ERR : rita_pkg::OUT_ZERO;
                        state_next    = rita_pkg::ST_IDLE;
                    end
                end
                else begin
                    state_next = rita_pkg::ST_DIVIDE;
                end
            end
            rita_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last && status.quo_zero) begin
                    state_next = rita_pkg::ST_SIGN;
                end
            end
            rita_pkg::ST_SIGN:
            begin
                if (status.neg) begin
                    if (status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = rita_pkg::OUT_MINUS;
                        state_next   = rita_pkg::ST_READ;
                    end
                end
                else begin
                    state_next = rita_pkg::ST_READ;
                end
            end
            rita_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = rita_pkg::ST_EMIT;
            end
            rita_pkg::ST_EMIT:
            begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = rita_pkg::OUT_DIGIT;
                    cmd.out_final = status.cnt_zero;
                    state_next    = status.cnt_zero ? rita_pkg::ST_IDLE : rita_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = rita_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rita_dp.sv =====
// ============================================================================
// rita_dp
// Datapath: sign handling, a shared radix divider that settles several
// quotient bits per cycle, the digit stack and the output register.
// ============================================================================
module rita_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rita_pkg::ctrl_cmd_t                    cmd,
    output rita_pkg::dp_status_t                   status,
    input  logic [rita_pkg::IN_W-1:0]              value,
    input  logic                                   signed_mode,
    input  logic [rita_pkg::RADIX_W-1:0]           radix,
    output logic [rita_pkg::CHAR_W-1:0]            character,
    output logic                                   final_res,
    output logic                                   bad_radix,
    output logic                                   out_valid,
    input  logic                                   out_ready
);

    localparam logic [rita_pkg::STEP_W-1:0] LAST_STEP = rita_pkg::STEP_W'(rita_pkg::DIV_STEPS - 1);

    logic [rita_pkg::DIV_W-1:0]    mag_reg;
    logic [rita_pkg::DIGIT_W-1:0]  rem_reg;
    logic [rita_pkg::RAD_W-1:0]    radix_reg;
    logic                          neg_reg;
    logic                          bad_reg;
    logic [rita_pkg::STEP_W-1:0]   step_reg;
    logic [rita_pkg::CNT_W-1:0]    cnt_reg;
    logic [rita_pkg::DIGIT_W-1:0]  rd_data_reg;
    logic [rita_pkg::DIGIT_W-1:0]  stack [rita_pkg::STACK_DEPTH];

    logic [rita_pkg::CHAR_W-1:0]   char_reg;
    logic                          final_reg;
    logic                          bad_out_reg;
    logic                          out_valid_reg;

    logic [rita_pkg::VALUE_BITS-1:0] v_in;
    logic                            neg_in;
    logic [rita_pkg::VALUE_BITS-1:0] mag_in;
    logic                            bad_in;

    logic [rita_pkg::DIV_W-1:0]    mag_next;
    logic [rita_pkg::DIGIT_W-1:0]  rem_next;
    logic [rita_pkg::CNT_W-1:0]    cnt_m1;
    logic [rita_pkg::CHAR_W-1:0]   char_sel;

    // Input decode: magnitude and radix check.
    always_comb
    begin
        v_in   = value[rita_pkg::VALUE_BITS-1:0];
        neg_in = signed_mode & v_in[rita_pkg::VALUE_BITS-1];
        mag_in = neg_in ? (~v_in + 1'b1) : v_in;
        bad_in = (radix < rita_pkg::RADIX_W'(rita_pkg::RADIX_MIN))
              || (radix > rita_pkg::RADIX_W'(rita_pkg::RADIX_MAX));
    end

    // One divider step: restoring division, several quotient bits per cycle.
    // The dividend shifts out at the top while quotient bits fill in below.
    always_comb
    begin
        logic [rita_pkg::RAD_W-1:0]   t;
        logic [rita_pkg::DIGIT_W-1:0] r;
        logic [rita_pkg::DIV_W-1:0]   m;
        r = rem_reg;
        m = mag_reg;
        for (int k = 0; k < rita_pkg::BITS_PER_STEP; k++) begin
            t = {r, m[rita_pkg::DIV_W-1]};
            m = {m[rita_pkg::DIV_W-2:0], 1'b0};
            if (t >= radix_reg) begin
                t    = t - radix_reg;
                m[0] = 1'b1;
            end
            r = t[rita_pkg::DIGIT_W-1:0];
        end
        mag_next = m;
        rem_next = r;
    end

    assign cnt_m1 = cnt_reg - rita_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.load_in) begin
            step_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step) begin
            step_reg <= (step_reg == LAST_STEP) ? '0 : step_reg + rita_pkg::STEP_W'(1);
            if (step_reg == LAST_STEP) begin
                cnt_reg <= cnt_reg + rita_pkg::CNT_W'(1);
            end
        end
        else if (cmd.rd_en) begin
            cnt_reg <= cnt_m1;
        end
    end

    // Payload registers of the conversion.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in) begin
            mag_reg   <= {{(rita_pkg::DIV_W-rita_pkg::VALUE_BITS){1'b0}}, mag_in};
            rem_reg   <= '0;
            radix_reg <= radix[rita_pkg::RAD_W-1:0];
            neg_reg   <= neg_in;
            bad_reg   <= bad_in;
        end
        else if (cmd.div_step) begin
            mag_reg <= mag_next;
            rem_reg <= (step_reg == LAST_STEP) ? '0 : rem_next;
        end
    end

    // Digit stack: pushed least significant first, read back in reverse.
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && (step_reg == LAST_STEP)) begin
            stack[cnt_reg[rita_pkg::ADDR_W-1:0]] <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en) begin
            rd_data_reg <= stack[cnt_m1[rita_pkg::ADDR_W-1:0]];
        end
    end

    // Output register.
    always_comb
    begin
        case (cmd.out_sel)
            rita_pkg::OUT_ERR:   char_sel = rita_pkg::CH_NONE;
            rita_pkg::OUT_ZERO:  char_sel = rita_pkg::CH_ZERO;
            rita_pkg::OUT_MINUS: char_sel = rita_pkg::CH_MINUS;
            rita_pkg::OUT_DIGIT: char_sel = rita_pkg::digit_char(rd_data_reg);
            default:             char_sel = rita_pkg::CH_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load) begin
            char_reg    <= char_sel;
            final_reg   <= cmd.out_final;
            bad_out_reg <= (cmd.out_sel == rita_pkg::OUT_ERR);
        end
    end

    assign character = char_reg;
    assign final_res = final_reg;
    assign bad_radix = bad_out_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        status.bad      = bad_reg;
        status.is_zero  = (mag_reg == '0);
        status.neg      = neg_reg;
        status.div_last = (step_reg == LAST_STEP);
        status.quo_zero = (mag_next == '0);
        status.cnt_zero = (cnt_reg == '0);
        status.out_free = !out_valid_reg || out_ready;
    end

endmodule
